// File: hw/rtl/cfq_pkg.sv
package cfq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int WORD_W    = 32;

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_DUMP = 2'd2;
	localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

endpackage

// File: hw/rtl/cfq_front.sv
module cfq_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [cfq_pkg::OP_W-1:0]         op,
	input  logic signed [cfq_pkg::WORD_W-1:0] push_value,
	output logic                             cmd_valid,
	output cfq_pkg::cmd_t                    cmd,
	input  logic                             cmd_pop
);

	localparam logic [1:0] QFULL = 2'd2;

	cfq_pkg::cmd_t slot_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          keep;

	assign in_ready  = cnt_q != QFULL;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = slot_q[rp_q];

	// reserved op codes are taken and dropped
	assign keep = in_valid && in_ready && (op != cfq_pkg::OP_RSVD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (keep) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(keep) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			slot_q[wp_q].op    <= op;
			slot_q[wp_q].value <= push_value;
		end
	end

endmodule

// File: hw/rtl/cfq_back.sv
module cfq_back #(
	parameter int DEPTH = cfq_pkg::DEPTH_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	input  cfq_pkg::cmd_t                      cmd,
	output logic                               cmd_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cfq_pkg::STATUS_W-1:0]       status,
	output logic signed [cfq_pkg::WORD_W-1:0]  read_value,
	output logic [CNT_W-1:0]                   occupancy,
	output logic                               last
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
	endfunction

	logic signed [cfq_pkg::WORD_W-1:0] mem [DEPTH];
	logic signed [cfq_pkg::WORD_W-1:0] rdata_q;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d, idx_q, idx_d, raddr;
	logic [CNT_W-1:0] count_q, count_d, left_q, left_d;
	logic             wr_en, rd_en, load, can_load, out_valid_q;

	logic [cfq_pkg::STATUS_W-1:0]      st_d, st_q;
	logic signed [cfq_pkg::WORD_W-1:0] val_d, val_q;
	logic [CNT_W-1:0]                  occ_d, occ_q;
	logic                              last_d, last_q;

	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		tail_d  = tail_q;
		idx_d   = idx_q;
		count_d = count_q;
		left_d  = left_q;
		raddr   = head_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		load    = 1'b0;
		cmd_pop = 1'b0;
		st_d    = cfq_pkg::ST_OK;
		val_d   = '0;
		occ_d   = count_q;
		last_d  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && can_load) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						cfq_pkg::OP_PUSH: begin
							load = 1'b1;
							if (count_q == FULL_CNT) begin
								st_d = cfq_pkg::ST_OVERFLOW;
							end else begin
								wr_en   = 1'b1;
								tail_d  = nxt(tail_q);
								count_d = count_q + CNT_W'(1);
								occ_d   = count_q + CNT_W'(1);
							end
						end
						cfq_pkg::OP_POP: begin
							if (count_q == '0) begin
								load = 1'b1;
								st_d = cfq_pkg::ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								state_d = S_POP;
							end
						end
						cfq_pkg::OP_DUMP: begin
							if (count_q == '0) begin
								load = 1'b1;
								st_d = cfq_pkg::ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								idx_d   = nxt(head_q);
								left_d  = count_q;
								state_d = S_DUMP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_POP: begin
				if (can_load) begin
					load    = 1'b1;
					val_d   = rdata_q;
					occ_d   = count_q - CNT_W'(1);
					head_d  = nxt(head_q);
					count_d = count_q - CNT_W'(1);
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				if (can_load) begin
					load   = 1'b1;
					val_d  = rdata_q;
					last_d = left_q == CNT_W'(1);
					if (left_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						rd_en  = 1'b1;
						raddr  = idx_q;
						idx_d  = nxt(idx_q);
						left_d = left_q - CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			left_q  <= left_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			st_q   <= st_d;
			val_q  <= val_d;
			occ_q  <= occ_d;
			last_q <= last_d;
		end
	end

	// entry store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= cmd.value;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = st_q;
	assign read_value = val_q;
	assign occupancy  = occ_q;
	assign last       = last_q;

endmodule

// File: hw/rtl/circular_fifo_queue_core.sv
// path: front slot, then result register; a pop adds the registered store read
// throughput: one push per cycle unless the output stalls; a pop waits in S_POP,
// because of the registered read of the entry store
// a dump stays in S_DUMP, one word per cycle unless the output stalls
// reset: asynchronous active low, queue empty, head and tail at zero
module circular_fifo_queue_core #(
	parameter int DEPTH = cfq_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cfq_pkg::OP_W-1:0]           op,
	input  logic signed [cfq_pkg::WORD_W-1:0]  push_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cfq_pkg::STATUS_W-1:0]       status,
	output logic signed [cfq_pkg::WORD_W-1:0]  read_value,
	output logic [CNT_W-1:0]                   occupancy,
	output logic                               last
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          cmd_valid;
	logic          cmd_pop;
	cfq_pkg::cmd_t cmd;

	cfq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.push_value (push_value),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	cfq_back #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.occupancy  (occupancy),
		.last       (last)
	);

endmodule

// File: hw/rtl/cfq_checker.sv
module cfq_checker #(
	parameter int DEPTH = cfq_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [cfq_pkg::STATUS_W-1:0]       status,
	input logic signed [cfq_pkg::WORD_W-1:0]  read_value,
	input logic [CNT_W-1:0]                   occupancy,
	input logic                               last
);

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(read_value) && $stable(occupancy) && $stable(last))
		else $error("result changed while stalled");

	a_fail_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cfq_pkg::ST_OK |-> read_value == '0 && last)
		else $error("failed beat not zero or not last");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cfq_pkg::ST_OVERFLOW |-> occupancy == FULL_CNT)
		else $error("overflow while not full");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cfq_pkg::ST_EMPTY |-> occupancy == '0)
		else $error("empty status with words stored");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= FULL_CNT)
		else $error("occupancy beyond depth");

endmodule

bind circular_fifo_queue_core cfq_checker #(
	.DEPTH (DEPTH),
	.CNT_W (CNT_W)
) u_cfq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.read_value (read_value),
	.occupancy  (occupancy),
	.last       (last)
);
